// File: rtl/wtep_pkg.sv
// Shared types, constants and register codes of the wireframe triangle edge projector.
package wtep_pkg;

	// Number of vertices in a triangle, and of edges drawn from it.
	localparam int NUM_VERTS = 3;
	// Register stages in one projection lane.
	localparam int LANE_DEPTH = 6;

	// Offset-binary centre of an input coordinate.
	localparam logic [15:0] CENTRE = 16'd32767;
	// Added to a negative product before the shift so that it truncates toward zero.
	localparam logic [50:0] ROUND_BIAS = 51'h3FFF_FFFF;

	// Record index of the last edge (c to a).
	localparam logic [1:0] LAST_EDGE = 2'd2;

	// Configuration register indexes.
	typedef enum logic [3:0] {
		REG_ORIGIN_X     = 4'd0,
		REG_ORIGIN_Y     = 4'd1,
		REG_SCALE_FACTOR = 4'd2,
		REG_ROT_SIN      = 4'd3,
		REG_ROT_COS      = 4'd4,
		REG_LINE_COLOR   = 4'd5,
		REG_H_RES        = 4'd6,
		REG_V_RES        = 4'd7
	} cfg_idx_t;

	// Live configuration seen by the lanes and the edge stage.
	typedef struct packed {
		logic [15:0]        origin_x;
		logic [15:0]        origin_y;
		logic [15:0]        scale_factor;
		logic signed [15:0] rot_sin;
		logic signed [15:0] rot_cos;
		logic [7:0]         line_color;
		logic [11:0]        h_res;
		logic [11:0]        v_res;
	} cfg_t;

	// Stage load enables shared by all lanes.
	typedef struct packed {
		logic [LANE_DEPTH-1:0] load;
	} lane_ctl_t;

	// One ordered line before the colour is attached.
	typedef struct packed {
		logic [11:0] start_x;
		logic [11:0] start_y;
		logic [11:0] end_x;
		logic [11:0] end_y;
	} edge_rec_t;

endpackage

// File: rtl/wtep_if.sv
// Handshake interfaces for triangles, line records and configuration writes.
interface wtep_tri_if;
	logic        valid;
	logic        ready;
	logic [15:0] vertex_a_x;
	logic [15:0] vertex_a_y;
	logic [15:0] vertex_a_z;
	logic [15:0] vertex_b_x;
	logic [15:0] vertex_b_y;
	logic [15:0] vertex_b_z;
	logic [15:0] vertex_c_x;
	logic [15:0] vertex_c_y;
	logic [15:0] vertex_c_z;

	modport source (
		output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
		       vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
		input  ready
	);
	modport sink (
		input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
		       vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
		output ready
	);
endinterface

interface wtep_line_if;
	logic        valid;
	logic        ready;
	logic [11:0] start_x;
	logic [3:0]  start_nibble;
	logic [11:0] start_y;
	logic [11:0] end_x;
	logic [3:0]  end_nibble;
	logic [11:0] end_y;
	logic        last_edge;

	modport source (
		output valid, start_x, start_nibble, start_y, end_x, end_nibble, end_y, last_edge,
		input  ready
	);
	modport sink (
		input  valid, start_x, start_nibble, start_y, end_x, end_nibble, end_y, last_edge,
		output ready
	);
endinterface

interface wtep_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/wtep_lane.sv
// One projection lane: centres, rotates, scales, offsets and clamps one vertex.
module wtep_lane (
	input  logic                clk,
	input  wtep_pkg::lane_ctl_t ctl,
	input  wtep_pkg::cfg_t      cfg,
	input  logic [15:0]         vx,
	input  logic [15:0]         vy,
	input  logic [15:0]         vz,
	output logic [11:0]         px,
	output logic [11:0]         py
);

	// Clamp a wrapped signed 16-bit screen position to 0..limit.
	function automatic logic [11:0] clamp_pos(input logic [15:0] w, input logic [11:0] limit);
		logic [11:0] res;
		if (w[15]) begin
			res = '0;
		end else if (w[14:0] > {3'b000, limit}) begin
			res = limit;
		end else begin
			res = w[11:0];
		end
		return res;
	endfunction

	logic signed [16:0] cx, cy, cz;
	logic signed [32:0] sin_cx_s1, cos_cz_s1, cos_cy_s1, sin_cz_s1;
	logic signed [33:0] r_s2   [2];
	logic signed [33:0] ph_s3  [2];
	logic [32:0]        pl_s3  [2];
	logic [50:0]        p_s4   [2];
	logic [15:0]        q_s5   [2];
	logic [11:0]        pos_s6 [2];
	logic signed [16:0] scale_s;

	// Centre the offset-binary coordinates.
	assign cx = signed'({1'b0, vx} - {1'b0, wtep_pkg::CENTRE});
	assign cy = signed'({1'b0, vy} - {1'b0, wtep_pkg::CENTRE});
	assign cz = signed'({1'b0, vz} - {1'b0, wtep_pkg::CENTRE});
	assign scale_s = signed'({1'b0, cfg.scale_factor});

	// Stage 1: the four rotation products.
	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			sin_cx_s1 <= cfg.rot_sin * cx;
			cos_cz_s1 <= cfg.rot_cos * cz;
			cos_cy_s1 <= cfg.rot_cos * cy;
			sin_cz_s1 <= cfg.rot_sin * cz;
		end
	end

	// Stage 2: rotated x and y.
	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			r_s2[0] <= signed'({sin_cx_s1[32], sin_cx_s1} + {cos_cz_s1[32], cos_cz_s1});
			r_s2[1] <= signed'({cos_cy_s1[32], cos_cy_s1} - {sin_cz_s1[32], sin_cz_s1});
		end
	end

	// Stages 3 to 6 are the same for both axes.
	for (genvar ax = 0; ax < 2; ax++) begin : g_axis
		logic [50:0] biased;
		logic [15:0] wrapped;
		logic [15:0] origin;
		logic [11:0] limit;

		assign origin = (ax == 0) ? cfg.origin_x : cfg.origin_y;
		assign limit  = (ax == 0) ? cfg.h_res : cfg.v_res;

		// Stage 3: the scale product split into a signed high and an unsigned low half.
		always_ff @(posedge clk) begin
			if (ctl.load[2]) begin
				ph_s3[ax] <= signed'(r_s2[ax][33:17]) * scale_s;
				pl_s3[ax] <= r_s2[ax][16:0] * cfg.scale_factor;
			end
		end

		// Stage 4: recombine the partial products.
		always_ff @(posedge clk) begin
			if (ctl.load[3]) begin
				p_s4[ax] <= {ph_s3[ax], 17'b0} + {18'b0, pl_s3[ax]};
			end
		end

		// Stage 5: shift right by 30 toward zero, keeping the low 16 bits.
		assign biased = p_s4[ax] + (p_s4[ax][50] ? wtep_pkg::ROUND_BIAS : '0);
		always_ff @(posedge clk) begin
			if (ctl.load[4]) begin
				q_s5[ax] <= biased[45:30];
			end
		end

		// Stage 6: add the origin, wrap to 16 bits and clamp to the screen.
		assign wrapped = q_s5[ax] + origin;
		always_ff @(posedge clk) begin
			if (ctl.load[5]) begin
				pos_s6[ax] <= clamp_pos(wrapped, limit);
			end
		end
	end

	assign px = pos_s6[0];
	assign py = pos_s6[1];

endmodule

// File: rtl/wtep_merge.sv
// Edge stage: builds the three ordered line records of a triangle and sends them in turn.
module wtep_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wtep_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [11:0]          px [wtep_pkg::NUM_VERTS],
	input  logic [11:0]          py [wtep_pkg::NUM_VERTS],
	wtep_line_if.source          line_out
);

	logic                valid_q;
	logic [1:0]          idx_q;
	wtep_pkg::edge_rec_t rec_q [wtep_pkg::NUM_VERTS];
	wtep_pkg::edge_rec_t rec_d [wtep_pkg::NUM_VERTS];
	logic                out_xfer;
	logic                load;
	logic                last;

	// Order each edge so that its start has the smaller y; ties keep the first vertex.
	always_comb begin
		for (int k = 0; k < wtep_pkg::NUM_VERTS; k++) begin
			int nxt;
			nxt = (k == wtep_pkg::NUM_VERTS - 1) ? 0 : k + 1;
			if (py[k] > py[nxt]) begin
				rec_d[k] = '{start_x: px[nxt], start_y: py[nxt], end_x: px[k], end_y: py[k]};
			end else begin
				rec_d[k] = '{start_x: px[k], start_y: py[k], end_x: px[nxt], end_y: py[nxt]};
			end
		end
	end

	assign last     = (idx_q == wtep_pkg::LAST_EDGE);
	assign out_xfer = line_out.valid && line_out.ready;
	assign in_ready = !valid_q || (out_xfer && last);
	assign load     = in_valid && in_ready;

	// Record buffer and the index of the record on offer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (out_xfer) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q <= rec_d;
		end
	end

	// Present the current record with the colour nibbles.
	assign line_out.valid        = valid_q;
	assign line_out.start_x      = rec_q[idx_q].start_x;
	assign line_out.start_y      = rec_q[idx_q].start_y;
	assign line_out.end_x        = rec_q[idx_q].end_x;
	assign line_out.end_y        = rec_q[idx_q].end_y;
	assign line_out.start_nibble = cfg.line_color[7:4];
	assign line_out.end_nibble   = cfg.line_color[3:0];
	assign line_out.last_edge    = last;

	// A transfer of an early record moves on to the next one of the same triangle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !last |=> valid_q && (idx_q == $past(idx_q) + 2'd1))
		else $error("edge index did not advance after a transfer");

	// Every record on offer is ordered by y.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> line_out.start_y <= line_out.end_y)
		else $error("line record not ordered by y");

	// Every record on offer lies on the screen.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (line_out.start_x <= cfg.h_res) && (line_out.end_x <= cfg.h_res)
			&& (line_out.end_y <= cfg.v_res))
		else $error("line record outside the clamp limits");

	// After the last record goes, the buffer is empty unless a new triangle came in.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && last && !in_valid |=> !valid_q)
		else $error("record buffer still full after the last edge");

endmodule

// File: rtl/wireframe_triangle_edge_projector.sv
// Top level of the wireframe triangle edge projector: registers, three lanes and the edge stage.
//
// Channel    Role   Transfer carries
// tri_in     sink   one triangle: three vertices of 16-bit x, y, z
// line_out   source one line record: start and end point, colour nibbles, last_edge
// cfg        sink   one register write: index and 16-bit data
//
// A triangle passes through six lane stages and the edge stage before its first record is on
// offer. Each triangle gives three records, one a cycle while line_out.ready is high, so the
// single result channel sets the sustained rate at which triangles are taken.
// Reset clears the pipeline and loads the register defaults; no clearing pass is needed.
// A stall on line_out fills the lane stages in turn before tri_in.ready falls.
module wireframe_triangle_edge_projector (
	input  logic         clk,
	input  logic         arst_n,
	wtep_tri_if.sink     tri_in,
	wtep_line_if.source  line_out,
	wtep_cfg_if.sink     cfg
);

	wtep_pkg::cfg_t      cfg_q;
	wtep_pkg::lane_ctl_t ctl;
	logic [wtep_pkg::LANE_DEPTH-1:0] v_q;
	logic [wtep_pkg::LANE_DEPTH:0]   go;
	logic                merge_ready;
	logic [15:0]         vx [wtep_pkg::NUM_VERTS];
	logic [15:0]         vy [wtep_pkg::NUM_VERTS];
	logic [15:0]         vz [wtep_pkg::NUM_VERTS];
	logic [11:0]         px [wtep_pkg::NUM_VERTS];
	logic [11:0]         py [wtep_pkg::NUM_VERTS];

	// Configuration registers; writes to unknown indexes are dropped.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x     <= 16'd0;
			cfg_q.origin_y     <= 16'd0;
			cfg_q.scale_factor <= 16'd256;
			cfg_q.rot_sin      <= 16'sd0;
			cfg_q.rot_cos      <= 16'sd32767;
			cfg_q.line_color   <= 8'd255;
			cfg_q.h_res        <= 12'd1024;
			cfg_q.v_res        <= 12'd600;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				wtep_pkg::REG_ORIGIN_X:     cfg_q.origin_x     <= cfg.data;
				wtep_pkg::REG_ORIGIN_Y:     cfg_q.origin_y     <= cfg.data;
				wtep_pkg::REG_SCALE_FACTOR: cfg_q.scale_factor <= cfg.data;
				wtep_pkg::REG_ROT_SIN:      cfg_q.rot_sin      <= signed'(cfg.data);
				wtep_pkg::REG_ROT_COS:      cfg_q.rot_cos      <= signed'(cfg.data);
				wtep_pkg::REG_LINE_COLOR:   cfg_q.line_color   <= cfg.data[7:0];
				wtep_pkg::REG_H_RES:        cfg_q.h_res        <= cfg.data[11:0];
				wtep_pkg::REG_V_RES:        cfg_q.v_res        <= cfg.data[11:0];
				default: ;
			endcase
		end
	end

	// A stage may take new data when it is empty or its contents move on.
	always_comb begin
		go[wtep_pkg::LANE_DEPTH] = merge_ready;
		for (int k = wtep_pkg::LANE_DEPTH - 1; k >= 0; k--) begin
			go[k] = !v_q[k] || go[k + 1];
		end
		for (int k = 0; k < wtep_pkg::LANE_DEPTH; k++) begin
			ctl.load[k] = go[k] && ((k == 0) ? tri_in.valid : v_q[k - 1]);
		end
	end

	assign tri_in.ready = go[0];

	// Stage occupancy shared by the three lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 0; k < wtep_pkg::LANE_DEPTH; k++) begin
				if (go[k]) begin
					v_q[k] <= (k == 0) ? tri_in.valid : v_q[k - 1];
				end
			end
		end
	end

	// One lane per vertex.
	assign vx[0] = tri_in.vertex_a_x;
	assign vy[0] = tri_in.vertex_a_y;
	assign vz[0] = tri_in.vertex_a_z;
	assign vx[1] = tri_in.vertex_b_x;
	assign vy[1] = tri_in.vertex_b_y;
	assign vz[1] = tri_in.vertex_b_z;
	assign vx[2] = tri_in.vertex_c_x;
	assign vy[2] = tri_in.vertex_c_y;
	assign vz[2] = tri_in.vertex_c_z;

	for (genvar l = 0; l < wtep_pkg::NUM_VERTS; l++) begin : g_lane
		wtep_lane u_lane (
			.clk (clk),
			.ctl (ctl),
			.cfg (cfg_q),
			.vx  (vx[l]),
			.vy  (vy[l]),
			.vz  (vz[l]),
			.px  (px[l]),
			.py  (py[l])
		);
	end

	// Edge stage combines the three projected vertices into line records.
	wtep_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (v_q[wtep_pkg::LANE_DEPTH-1]),
		.in_ready (merge_ready),
		.px       (px),
		.py       (py),
		.line_out (line_out)
	);

endmodule
